/* rtl/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page cache package
// Shared widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package lpc_pkg;
    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int PIN_BITS = 8;
    localparam int TAG_W    = 64;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [PIN_BITS-1:0] t_pins;

    localparam logic [2:0] MODE_GET   = 3'd0;
    localparam logic [2:0] MODE_PIN   = 3'd1;
    localparam logic [2:0] MODE_UNPIN = 3'd2;
    localparam logic [2:0] MODE_DIRTY = 3'd3;
    localparam logic [2:0] MODE_EVICT = 3'd4;
    localparam logic [2:0] MODE_FLUSH = 3'd5;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_OK       = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BUSY     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_FLUSHED  = 3'd6;
    localparam logic [2:0] ST_NODIRTY  = 3'd7;

    typedef struct packed {
        logic        strobe;
        logic [2:0]  status;
        t_idx        frame;
        logic [TAG_W-1:0] page_id;
        t_pins       pins;
        logic        dirty;
        logic        last;
    } t_result;
endpackage

/* rtl/lru_page_cache_with_pins.sv */
// ----------------------------------------------------------------------------
// LRU page cache with pins
// Fully associative page tag store with LRU order, pin counts and dirty marks.
// ----------------------------------------------------------------------------
// One frame is examined per cycle by a single compare unit under a sequencer.
// The tags, pin counts and ranks sit in memories with a registered read. A
// lookup is one pass that stops early on a hit. A get hit adds a recency pass.
// A get miss adds an insert pass, and when the store is at capacity a victim
// pass and a removal pass before it. An evict is a victim pass and a removal
// pass, with its result after the first. A flush is one pass and then a final
// state that gives the last result. Each result is on the ports for one cycle,
// marked by o_valid, and cannot be stalled. busy is high from acceptance and
// falls in the cycle that carries the last result of the item, but an evict
// holds busy through its removal pass. An evict on an empty store answers in
// the next cycle without raising busy, and modes 6 and 7 are ignored.
module lru_page_cache_with_pins
    import lpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_data,
    input  logic [2:0]       i_mode,
    input  logic [63:0]      i_page_id,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [5:0]       o_frame,
    output logic [63:0]      o_out_page_id,
    output logic [7:0]       o_pin_count,
    output logic             o_dirty_mark,
    output logic             o_last
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_FIND   = 8'b00000010,
        S_VICT   = 8'b00000100,
        S_REMOVE = 8'b00001000,
        S_INSERT = 8'b00010000,
        S_TOUCH  = 8'b00100000,
        S_FLUSH  = 8'b01000000,
        S_FEND   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_cap;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [ENTRIES-1:0] r_dirty, n_dirty;
    logic [TAG_W-1:0] m_tag [ENTRIES];
    t_pins m_pins [ENTRIES];
    t_idx m_rank [ENTRIES];
    logic [TAG_W-1:0] r_rd_tag;
    t_pins r_rd_pins;
    t_idx r_rd_rank;
    t_cnt r_count, n_count;
    logic [2:0] r_mode, n_mode;
    logic [TAG_W-1:0] r_id, n_id;
    logic [TAG_W-1:0] r_vtag, n_vtag;
    t_idx r_i, n_i;
    t_idx r_pi;
    t_idx r_f, n_f;
    t_idx r_rank, n_rank;
    t_idx r_free, n_free;
    logic r_pv, n_pv;
    logic r_found, n_found;
    logic r_free_ok, n_free_ok;
    logic r_any, n_any;
    t_result r_out, n_out;
    t_result r_hold, n_hold;
    logic [6:0] eff_cap;
    logic cur_v;
    logic pass_end;
    logic better;
    logic w_tag_we, w_pins_we, w_rank_we;
    logic [TAG_W-1:0] w_tag;
    t_pins w_pins;
    t_idx w_rank;

    always_comb begin
        eff_cap = r_cap;
        if (r_cap == 7'd0) eff_cap = 7'd1;
        if (r_cap > 7'(ENTRIES)) eff_cap = 7'(ENTRIES);
    end

    assign cur_v    = r_pv && r_valid[r_pi];
    assign pass_end = r_pv && (r_pi == t_idx'(ENTRIES - 1));
    assign better   = cur_v && (r_rd_pins == '0) && (!r_found || (r_rd_rank > r_rank));

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_count = r_count;
        n_mode = r_mode;
        n_id = r_id;
        n_vtag = r_vtag;
        n_f = r_f;
        n_rank = r_rank;
        n_free = r_free;
        n_found = r_found;
        n_free_ok = r_free_ok;
        n_any = r_any;
        n_hold = r_hold;
        n_out = r_out;
        n_out.strobe = 1'b0;
        w_tag_we = 1'b0;
        w_pins_we = 1'b0;
        w_rank_we = 1'b0;
        w_tag = r_id;
        w_pins = '0;
        w_rank = '0;
        if (r_state inside {S_FIND, S_VICT, S_REMOVE, S_INSERT, S_TOUCH, S_FLUSH}) begin
            n_i = r_i + 1'b1;
            n_pv = 1'b1;
        end else begin
            n_i = '0;
            n_pv = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode = i_mode;
                    n_id = i_page_id;
                    n_found = 1'b0;
                    n_free_ok = 1'b0;
                    n_any = 1'b0;
                    case (i_mode)
                        MODE_EVICT: begin
                            if (r_count == '0) begin
                                n_out = '{1'b1, ST_EMPTY, '0, '0, '0, 1'b0, 1'b1};
                            end else n_state = S_VICT;
                        end
                        MODE_FLUSH: n_state = S_FLUSH;
                        default: begin
                            if (i_mode inside {MODE_GET, MODE_PIN, MODE_UNPIN, MODE_DIRTY})
                                n_state = S_FIND;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (cur_v && r_rd_tag == r_id) begin
                    n_i = '0;
                    n_pv = 1'b0;
                    n_f = r_pi;
                    n_rank = r_rd_rank;
                    case (r_mode)
                        MODE_GET: begin
                            n_out = '{1'b0, ST_HIT, r_pi, r_id, r_rd_pins, r_dirty[r_pi],
                                      1'b1};
                            n_state = S_TOUCH;
                        end
                        MODE_PIN: begin
                            w_pins = (r_rd_pins != '1) ? r_rd_pins + 1'b1 : r_rd_pins;
                            w_pins_we = 1'b1;
                            n_out = '{1'b1, ST_OK, r_pi, r_id, w_pins, r_dirty[r_pi], 1'b1};
                            n_state = S_IDLE;
                        end
                        MODE_UNPIN: begin
                            w_pins = (r_rd_pins != '0) ? r_rd_pins - 1'b1 : r_rd_pins;
                            w_pins_we = 1'b1;
                            n_out = '{1'b1, ST_OK, r_pi, r_id, w_pins, r_dirty[r_pi], 1'b1};
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_dirty[r_pi] = 1'b1;
                            n_out = '{1'b1, ST_OK, r_pi, r_id, r_rd_pins, 1'b1, 1'b1};
                            n_state = S_IDLE;
                        end
                    endcase
                end else begin
                    if (r_pv && !r_valid[r_pi] && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free = r_pi;
                    end
                    if (pass_end) begin
                        n_i = '0;
                        n_pv = 1'b0;
                        if (r_mode != MODE_GET) begin
                            n_out = '{1'b1, ST_NOTFOUND, '0, r_id, '0, 1'b0, 1'b1};
                            n_state = S_IDLE;
                        end else if (r_count + 7'd1 > eff_cap) begin
                            n_state = S_VICT;
                        end else if (n_free_ok) begin
                            n_f = n_free;
                            n_state = S_INSERT;
                        end else begin
                            n_out = '{1'b1, ST_BUSY, '0, r_id, '0, 1'b0, 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_VICT: begin
                if (better) begin
                    n_found = 1'b1;
                    n_f = r_pi;
                    n_rank = r_rd_rank;
                    n_vtag = r_rd_tag;
                end
                if (pass_end) begin
                    n_i = '0;
                    n_pv = 1'b0;
                    if (!n_found) begin
                        n_out = '{1'b1, ST_BUSY, '0, (r_mode == MODE_GET) ? r_id : '0, '0,
                                  1'b0, 1'b1};
                        n_state = S_IDLE;
                    end else begin
                        n_valid[n_f] = 1'b0;
                        n_count = r_count - 1'b1;
                        if (r_mode == MODE_EVICT)
                            n_out = '{1'b1, ST_OK, n_f, n_vtag, '0, r_dirty[n_f], 1'b1};
                        n_free_ok = 1'b0;
                        n_state = S_REMOVE;
                    end
                end
            end
            S_REMOVE: begin
                if (cur_v && r_rd_rank > r_rank) begin
                    w_rank_we = 1'b1;
                    w_rank = r_rd_rank - 1'b1;
                end
                if (r_pv && !r_valid[r_pi] && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free = r_pi;
                end
                if (pass_end) begin
                    n_i = '0;
                    n_pv = 1'b0;
                    if (r_mode != MODE_GET) begin
                        n_state = S_IDLE;
                    end else if (n_free_ok) begin
                        n_f = n_free;
                        n_state = S_INSERT;
                    end else begin
                        n_out = '{1'b1, ST_BUSY, '0, r_id, '0, 1'b0, 1'b1};
                        n_state = S_IDLE;
                    end
                end
            end
            S_INSERT: begin
                if (r_pv && r_pi == r_f) begin
                    w_tag_we = 1'b1;
                    w_tag = r_id;
                    w_pins_we = 1'b1;
                    w_pins = '0;
                    w_rank_we = 1'b1;
                    w_rank = '0;
                end else if (cur_v) begin
                    w_rank_we = 1'b1;
                    w_rank = r_rd_rank + 1'b1;
                end
                if (pass_end) begin
                    n_i = '0;
                    n_pv = 1'b0;
                    n_valid[r_f] = 1'b1;
                    n_dirty[r_f] = 1'b0;
                    n_count = r_count + 1'b1;
                    n_out = '{1'b1, ST_INSERTED, r_f, r_id, '0, 1'b0, 1'b1};
                    n_state = S_IDLE;
                end
            end
            S_TOUCH: begin
                if (r_pv && r_pi == r_f) begin
                    w_rank_we = 1'b1;
                    w_rank = '0;
                end else if (cur_v && r_rd_rank < r_rank) begin
                    w_rank_we = 1'b1;
                    w_rank = r_rd_rank + 1'b1;
                end
                if (pass_end) begin
                    n_i = '0;
                    n_pv = 1'b0;
                    n_out.strobe = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                // Each dirty page is held back one find so the final one can carry last.
                if (cur_v && r_dirty[r_pi]) begin
                    n_dirty[r_pi] = 1'b0;
                    if (r_any) begin
                        n_out = r_hold;
                        n_out.strobe = 1'b1;
                    end
                    n_hold = '{1'b0, ST_FLUSHED, r_pi, r_rd_tag, r_rd_pins, 1'b0, 1'b0};
                    n_any = 1'b1;
                end
                if (pass_end) begin
                    n_i = '0;
                    n_pv = 1'b0;
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                if (r_any) begin
                    n_out = r_hold;
                    n_out.strobe = 1'b1;
                    n_out.last = 1'b1;
                end else begin
                    n_out = '{1'b1, ST_NODIRTY, '0, '0, '0, 1'b0, 1'b1};
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap <= 7'd64;
            r_valid <= '0;
            r_dirty <= '0;
            r_count <= '0;
            r_mode <= MODE_GET;
            r_id <= '0;
            r_vtag <= '0;
            r_i <= '0;
            r_pi <= '0;
            r_f <= '0;
            r_rank <= '0;
            r_free <= '0;
            r_pv <= 1'b0;
            r_found <= 1'b0;
            r_free_ok <= 1'b0;
            r_any <= 1'b0;
            r_out <= '0;
            r_hold <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            r_state <= n_state;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_count <= n_count;
            r_mode <= n_mode;
            r_id <= n_id;
            r_vtag <= n_vtag;
            r_i <= n_i;
            r_pi <= r_i;
            r_f <= n_f;
            r_rank <= n_rank;
            r_free <= n_free;
            r_pv <= n_pv;
            r_found <= n_found;
            r_free_ok <= n_free_ok;
            r_any <= n_any;
            r_out <= n_out;
            r_hold <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) m_tag[r_pi] <= w_tag;
        if (w_pins_we) m_pins[r_pi] <= w_pins;
        if (w_rank_we) m_rank[r_pi] <= w_rank;
        r_rd_tag <= m_tag[r_i];
        r_rd_pins <= m_pins[r_i];
        r_rd_rank <= m_rank[r_i];
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_out.strobe;
    assign o_status = r_out.status;
    assign o_frame = r_out.frame;
    assign o_out_page_id = r_out.page_id;
    assign o_pin_count = r_out.pins;
    assign o_dirty_mark = r_out.dirty;
    assign o_last = r_out.last;
endmodule

/* rtl/lpc_checker.sv */
// ----------------------------------------------------------------------------
// LRU page cache checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
module lpc_checker
    import lpc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic [2:0] i_mode,
    input logic o_valid,
    input logic [2:0] o_status,
    input logic o_dirty_mark,
    input logic o_last
);
    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FLUSHED |-> !o_dirty_mark) else $error("flush dirty");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FLUSHED |-> o_last) else $error("last missing");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode <= MODE_FLUSH |=> busy || o_valid) else $error("not busy");
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy) else $error("item ended early");
endmodule

bind lru_page_cache_with_pins lpc_checker u_chk (.*);
